// ===== src/gemm_alpha_beta_bias_top_defines.svh =====
// assertion macros for the gemm top level
// used by gemm_alpha_beta_bias_top only
`ifndef GEMM_ALPHA_BETA_BIAS_TOP_DEFINES_SVH
`define GEMM_ALPHA_BETA_BIAS_TOP_DEFINES_SVH
// clocked implication, disabled while reset is low
`define GABB_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GABB_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/gabb_pkg.sv =====
// shared types and constants for the gemm block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gabb_pkg;
    localparam int MAX_M_DEF = 8;
    localparam int MAX_K_DEF = 16;
    localparam int MAX_N_DEF = 8;
    localparam int AB_DEPTH = 128;
    localparam int C_DEPTH = 64;
    localparam int AW = 7;
    localparam int CW = 6;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_LOAD_C = 2'd2,
        ACT_START  = 2'd3
    } action_t;

    typedef enum logic [7:0] {
        REG_M_ROWS  = 8'd0,
        REG_K_DEPTH = 8'd1,
        REG_N_COLS  = 8'd2,
        REG_TRANS_A = 8'd3,
        REG_TRANS_B = 8'd4,
        REG_ALPHA   = 8'd5,
        REG_BETA    = 8'd6,
        REG_C_LEN   = 8'd7
    } reg_idx_t;

    // control handed down the cell chain with each product
    typedef struct packed {
        logic       vld;
        logic       first;
        logic       fin;
        logic [5:0] idx;
        logic       last;
    } cell_ctl_t;

    function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
        if (v > 35'sd32767) return 16'sh7fff;
        else if (v < -35'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction
endpackage
`default_nettype wire

// ===== src/gabb_cell.sv =====
// one pipeline cell: registers a control word and a data word, hands both on
// uses gabb_pkg
`timescale 1ns / 1ps
`default_nettype none
module gabb_cell #(
    parameter int DW = 32
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  gabb_pkg::cell_ctl_t    ctl_in,
    input  wire  [DW-1:0]          data_in,
    output gabb_pkg::cell_ctl_t    ctl_out,
    output logic [DW-1:0]          data_out
);
    gabb_pkg::cell_ctl_t ctl_reg;
    logic [DW-1:0] data_reg;

    // control word with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_in;
        end
    end

    // payload word
    always_ff @(posedge aclk) begin
        data_reg <= data_in;
    end

    assign ctl_out = ctl_reg;
    assign data_out = data_reg;
endmodule
`default_nettype wire

// ===== src/gemm_alpha_beta_bias_top.sv =====
// Fixed-point GEMM, Y = alpha*op(A)*op(B) + beta*C, signed Q8.8.
// Load items (A, B, C) are taken one per cycle while idle. A start item runs
// M*N*K multiply-accumulate steps, one per cycle, through a chain of cells:
// memory read, multiply, accumulate, alpha and beta scale, bias add and
// saturate, output fifo. With zero depth each element still takes one step.
// Output stalls hold a run back; issue pauses while eight results are
// outstanding. The next item is taken once the run's last result has left.
// Stores need no clearing.
// uses gabb_pkg, gabb_cell and gemm_alpha_beta_bias_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "gemm_alpha_beta_bias_top_defines.svh"
module gemm_alpha_beta_bias_top #(
    parameter int MAX_M = gabb_pkg::MAX_M_DEF,
    parameter int MAX_K = gabb_pkg::MAX_K_DEF,
    parameter int MAX_N = gabb_pkg::MAX_N_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_we,
    input  wire  [7:0]        cfg_index,
    input  wire  [15:0]       cfg_data,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire  [1:0]        s_action,
    input  wire  [6:0]        s_position,
    input  wire signed [15:0] s_value,
    output logic              m_valid,
    input  wire               m_ready,
    output logic [5:0]        m_y_index,
    output logic signed [15:0] m_y_value,
    output logic              m_last
);
    localparam int KW = $clog2(MAX_K + 1);
    localparam int FD = 8;

    // configuration registers
    logic [3:0] m_rows_reg, n_cols_reg;
    logic [4:0] k_depth_reg;
    logic trans_a_reg, trans_b_reg;
    logic signed [15:0] alpha_reg, beta_reg;
    logic [6:0] c_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_rows_reg <= 4'd1; k_depth_reg <= 5'd1; n_cols_reg <= 4'd1;
            trans_a_reg <= 1'b0; trans_b_reg <= 1'b0;
            alpha_reg <= 16'sd256; beta_reg <= 16'sd256; c_len_reg <= 7'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                gabb_pkg::REG_M_ROWS:  m_rows_reg <= cfg_data[3:0];
                gabb_pkg::REG_K_DEPTH: k_depth_reg <= cfg_data[4:0];
                gabb_pkg::REG_N_COLS:  n_cols_reg <= cfg_data[3:0];
                gabb_pkg::REG_TRANS_A: trans_a_reg <= cfg_data[0];
                gabb_pkg::REG_TRANS_B: trans_b_reg <= cfg_data[0];
                gabb_pkg::REG_ALPHA:   alpha_reg <= cfg_data;
                gabb_pkg::REG_BETA:    beta_reg <= cfg_data;
                gabb_pkg::REG_C_LEN:   c_len_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // clamped dimensions
    logic [3:0] dim_m, dim_n;
    logic [6:0] dim_k, dim_cl;
    assign dim_m = (m_rows_reg > 4'(MAX_M)) ? 4'(MAX_M) : m_rows_reg;
    assign dim_n = (n_cols_reg > 4'(MAX_N)) ? 4'(MAX_N) : n_cols_reg;
    assign dim_k = (7'(k_depth_reg) > 7'(MAX_K)) ? 7'(MAX_K) : 7'(k_depth_reg);
    assign dim_cl = (c_len_reg > 7'd64) ? 7'd64 : c_len_reg;

    // sequencer state
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;
    state_t state_reg, state_next;

    logic [3:0] m_reg, n_reg;
    logic [KW-1:0] k_reg;
    logic [5:0] idx_reg;
    logic [6:0] ai_reg, bi_reg;   // running store addresses
    logic [6:0] arow_reg, bcol_reg;
    logic [6:0] cidx_reg;         // running idx mod c_len
    logic [6:0] outst_reg;        // results issued but not delivered

    logic start_acc, issue, run_done_pending;
    logic k_end, n_end, m_end;
    gabb_pkg::action_t act;
    assign act = gabb_pkg::action_t'(s_action);

    // a step is issued only while fewer than FD results are outstanding
    assign s_ready = (state_reg == ST_IDLE);
    assign start_acc = s_valid && s_ready && (act == gabb_pkg::ACT_START);
    assign issue = (state_reg == ST_RUN) && (outst_reg < 7'(FD));
    assign k_end = (7'(k_reg) + 7'd1 >= dim_k);
    assign n_end = (n_reg + 4'd1 == dim_n);
    assign m_end = (m_reg + 4'd1 == dim_m);

    // stores
    logic signed [15:0] a_mem [gabb_pkg::AB_DEPTH];
    logic signed [15:0] b_mem [gabb_pkg::AB_DEPTH];
    logic signed [15:0] c_mem [gabb_pkg::C_DEPTH];
    logic signed [15:0] a_rd_reg, b_rd_reg, c_rd_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && act == gabb_pkg::ACT_LOAD_A)
            a_mem[s_position] <= s_value;
        a_rd_reg <= a_mem[ai_reg];
    end
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && act == gabb_pkg::ACT_LOAD_B)
            b_mem[s_position] <= s_value;
        b_rd_reg <= b_mem[bi_reg];
    end
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && act == gabb_pkg::ACT_LOAD_C && !s_position[6])
            c_mem[s_position[5:0]] <= s_value;
        c_rd_reg <= c_mem[cidx_reg[5:0]];
    end

    // address and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_reg <= '0; n_reg <= '0; k_reg <= '0; idx_reg <= '0;
            ai_reg <= '0; bi_reg <= '0; arow_reg <= '0; bcol_reg <= '0;
            cidx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (start_acc) begin
                m_reg <= '0; n_reg <= '0; k_reg <= '0; idx_reg <= '0;
                ai_reg <= '0; bi_reg <= '0; arow_reg <= '0; bcol_reg <= '0;
                cidx_reg <= '0;
            end else if (issue) begin
                if (!k_end) begin
                    k_reg <= k_reg + 1'b1;
                    ai_reg <= ai_reg + (trans_a_reg ? 7'(dim_m) : 7'd1);
                    bi_reg <= bi_reg + (trans_b_reg ? 7'd1 : 7'(dim_n));
                end else begin
                    k_reg <= '0;
                    idx_reg <= idx_reg + 6'd1;
                    cidx_reg <= (cidx_reg + 7'd1 >= dim_cl) ? 7'd0 : cidx_reg + 7'd1;
                    if (!n_end) begin
                        n_reg <= n_reg + 4'd1;
                        ai_reg <= arow_reg;
                        bi_reg <= trans_b_reg ? bcol_reg + dim_k : bcol_reg + 7'd1;
                        bcol_reg <= trans_b_reg ? bcol_reg + dim_k : bcol_reg + 7'd1;
                    end else begin
                        n_reg <= '0;
                        m_reg <= m_reg + 4'd1;
                        bi_reg <= '0; bcol_reg <= '0;
                        ai_reg <= trans_a_reg ? arow_reg + 7'd1 : arow_reg + dim_k;
                        arow_reg <= trans_a_reg ? arow_reg + 7'd1 : arow_reg + dim_k;
                    end
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start_acc) state_next = (dim_m == 4'd0 || dim_n == 4'd0)
                                                 ? ST_WAIT : ST_RUN;
            ST_RUN:  if (issue && k_end && n_end && m_end) state_next = ST_WAIT;
            ST_WAIT: if (!run_done_pending) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control issued into the chain
    gabb_pkg::cell_ctl_t ctl0, ctl1, ctl2, ctl3, ctl4, ctl5;
    always_comb begin
        ctl0.vld = issue;
        ctl0.first = (k_reg == '0);
        ctl0.fin = k_end;
        ctl0.idx = idx_reg;
        ctl0.last = n_end && m_end;
    end

    // cell 1: memory read stage, forwards zero-depth flag
    logic [0:0] zk1;
    gabb_cell #(.DW(1)) u_c1 (.aclk(aclk), .aresetn(aresetn), .ctl_in(ctl0),
        .data_in(dim_k == 7'd0), .ctl_out(ctl1), .data_out(zk1));

    // cell 2: product
    logic signed [31:0] prod, prod2;
    assign prod = zk1[0] ? 32'sd0 : a_rd_reg * b_rd_reg;
    logic signed [15:0] c2;
    gabb_cell #(.DW(48)) u_c2 (.aclk(aclk), .aresetn(aresetn), .ctl_in(ctl1),
        .data_in({c_rd_reg, prod}), .ctl_out(ctl2), .data_out({c2, prod2}));

    // accumulator
    logic signed [35:0] acc_reg;
    logic signed [35:0] acc_sum;
    assign acc_sum = (ctl2.first ? 36'sd0 : acc_reg) + 36'(prod2);
    always_ff @(posedge aclk) begin
        if (ctl2.vld) acc_reg <= acc_sum;
    end

    // cell 3: finished sum handed on
    gabb_pkg::cell_ctl_t ctl2f;
    always_comb begin
        ctl2f = ctl2;
        ctl2f.vld = ctl2.vld && ctl2.fin;
    end
    logic signed [35:0] s3;
    logic signed [15:0] c3;
    gabb_cell #(.DW(52)) u_c3 (.aclk(aclk), .aresetn(aresetn), .ctl_in(ctl2f),
        .data_in({c2, acc_sum}), .ctl_out(ctl3), .data_out({c3, s3}));

    // cell 4: scale products (36x16 and 16x16)
    logic signed [51:0] sa, sa4;
    logic signed [31:0] bc, bc4;
    assign sa = s3 * alpha_reg;
    assign bc = (dim_cl == 7'd0) ? 32'sd0 : beta_reg * c3;
    gabb_cell #(.DW(84)) u_c4 (.aclk(aclk), .aresetn(aresetn), .ctl_in(ctl3),
        .data_in({bc, sa}), .ctl_out(ctl4), .data_out({bc4, sa4}));

    // cell 5: floor shifts, add, saturate
    logic signed [34:0] ysum;
    logic signed [15:0] ysat, y5;
    assign ysum = 35'(sa4 >>> 16) + 35'(bc4 >>> 8);
    assign ysat = gabb_pkg::sat16(ysum);
    gabb_cell #(.DW(16)) u_c5 (.aclk(aclk), .aresetn(aresetn), .ctl_in(ctl4),
        .data_in(ysat), .ctl_out(ctl5), .data_out(y5));

    // output fifo, holds every in-flight result
    logic [22:0] fifo_mem [FD];
    logic [2:0] wp_reg, rp_reg;
    logic [3:0] cnt_reg;
    logic pop;
    assign pop = m_valid && m_ready;
    always_ff @(posedge aclk) begin
        if (ctl5.vld) fifo_mem[wp_reg] <= {ctl5.last, ctl5.idx, y5};
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (ctl5.vld) wp_reg <= wp_reg + 3'd1;
            if (pop) rp_reg <= rp_reg + 3'd1;
            cnt_reg <= cnt_reg + 4'(ctl5.vld) - 4'(pop);
        end
    end
    assign m_valid = (cnt_reg != 4'd0);
    assign {m_last, m_y_index, m_y_value} = fifo_mem[rp_reg];

    // issue is throttled by in-flight count so the fifo cannot overflow
    always_ff @(posedge aclk) begin
        if (!aresetn) outst_reg <= '0;
        else outst_reg <= outst_reg + 7'(issue && k_end) - 7'(pop);
    end
    assign run_done_pending = (outst_reg != 7'd0);

    `GABB_ASSERT_IMP(a_no_overflow, aclk, aresetn, ctl5.vld, cnt_reg < 4'(FD) || pop, "fifo overflow")
    `GABB_ASSERT_IMP(a_idle_empty, aclk, aresetn, state_reg == ST_IDLE, outst_reg == 7'd0, "idle with results pending")
    `GABB_ASSERT_NXT(a_start_runs, aclk, aresetn, start_acc, state_reg != ST_IDLE, "start did not leave idle")
endmodule
`default_nettype wire

// ===== tb/sv/gemm_alpha_beta_bias_top_tb.sv =====
// testbench for gemm_alpha_beta_bias_top: loads A, B and C, runs starts under
// several register settings and checks every result against an internal predictor
// depends on gabb_pkg and gemm_alpha_beta_bias_top
`timescale 1ns / 1ps
module gemm_alpha_beta_bias_top_tb;
    localparam logic [7:0] UNUSED_REG = 8'd200;
    localparam int DRAIN_WAIT = 40;
    // every start reads only below these store positions
    localparam int AB_FILL = 16;
    localparam int C_FILL = 16;

    typedef struct {
        logic [5:0]         idx;
        logic signed [15:0] val;
        logic               last;
    } y_elem_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [7:0] cfg_index;
    logic [15:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_action;
    logic [6:0] s_position;
    logic signed [15:0] s_value;
    logic m_valid;
    logic m_ready;
    logic [5:0] m_y_index;
    logic signed [15:0] m_y_value;
    logic m_last;

    // mirrored block state
    logic [15:0] a_mem [gabb_pkg::AB_DEPTH];
    logic [15:0] b_mem [gabb_pkg::AB_DEPTH];
    logic [15:0] c_mem [gabb_pkg::C_DEPTH];
    logic [3:0] rows_q, cols_q;
    logic [4:0] depth_q;
    logic ta_q, tb_q;
    logic [15:0] alpha_q, beta_q;
    logic [6:0] clen_q;

    y_elem_t y_expected[$];
    int mismatches = 0;
    int out_stall = 0;
    bit no_idle = 0;

    gemm_alpha_beta_bias_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_position(s_position), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_y_index(m_y_index),
        .m_y_value(m_y_value), .m_last(m_last)
    );

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // hard time limit
    initial begin
        #5ms;
        $display("gemm_alpha_beta_bias_top test failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // expected elements of Y for one start item, from the current state
    function automatic void predict_gemm();
        int mm, kk, nn, cl, ai, bi, idx;
        longint acc, y;
        mm = (rows_q > gabb_pkg::MAX_M_DEF) ? gabb_pkg::MAX_M_DEF : rows_q;
        kk = (depth_q > gabb_pkg::MAX_K_DEF) ? gabb_pkg::MAX_K_DEF : depth_q;
        nn = (cols_q > gabb_pkg::MAX_N_DEF) ? gabb_pkg::MAX_N_DEF : cols_q;
        cl = (clen_q > gabb_pkg::C_DEPTH) ? gabb_pkg::C_DEPTH : clen_q;
        for (int m = 0; m < mm; m++) begin
            for (int n = 0; n < nn; n++) begin
                y_elem_t e;
                acc = 0;
                for (int k = 0; k < kk; k++) begin
                    ai = ta_q ? (k * mm + m) : (m * kk + k);
                    bi = tb_q ? (n * kk + k) : (k * nn + n);
                    acc += longint'($signed(a_mem[ai % gabb_pkg::AB_DEPTH]))
                         * longint'($signed(b_mem[bi % gabb_pkg::AB_DEPTH]));
                end
                idx = m * nn + n;
                y = (acc * longint'($signed(alpha_q))) >>> 16;
                if (cl != 0)
                    y += (longint'($signed(beta_q)) * longint'($signed(c_mem[idx % cl]))) >>> 8;
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
                e.idx = idx[5:0];
                e.val = y[15:0];
                e.last = (idx + 1 == mm * nn);
                y_expected.push_back(e);
            end
        end
    endfunction

    // register write, only while idle; no item is offered meanwhile
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        s_valid <= 0;
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge aclk);
        cfg_we <= 0;
        case (idx)
            gabb_pkg::REG_M_ROWS:  rows_q = data[3:0];
            gabb_pkg::REG_K_DEPTH: depth_q = data[4:0];
            gabb_pkg::REG_N_COLS:  cols_q = data[3:0];
            gabb_pkg::REG_TRANS_A: ta_q = data[0];
            gabb_pkg::REG_TRANS_B: tb_q = data[0];
            gabb_pkg::REG_ALPHA:   alpha_q = data;
            gabb_pkg::REG_BETA:    beta_q = data;
            gabb_pkg::REG_C_LEN:   clen_q = data[6:0];
            default: ;
        endcase
    endtask

    task automatic set_shape(input int m, input int k, input int n, input bit ta,
                             input bit tb, input int al, input int be, input int cl);
        write_reg(gabb_pkg::REG_M_ROWS, 16'(m));
        write_reg(gabb_pkg::REG_K_DEPTH, 16'(k));
        write_reg(gabb_pkg::REG_N_COLS, 16'(n));
        write_reg(gabb_pkg::REG_TRANS_A, 16'(ta));
        write_reg(gabb_pkg::REG_TRANS_B, 16'(tb));
        write_reg(gabb_pkg::REG_ALPHA, 16'(al));
        write_reg(gabb_pkg::REG_BETA, 16'(be));
        write_reg(gabb_pkg::REG_C_LEN, 16'(cl));
    endtask

    // send one item; called and returns at a falling edge
    task automatic send_item(input gabb_pkg::action_t act, input logic [6:0] pos,
                             input logic [15:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_action <= act;
        s_position <= pos;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        case (act)
            gabb_pkg::ACT_LOAD_A: a_mem[pos] = val;
            gabb_pkg::ACT_LOAD_B: b_mem[pos] = val;
            gabb_pkg::ACT_LOAD_C: if (pos < gabb_pkg::C_DEPTH) c_mem[pos] = val;
            default: predict_gemm();
        endcase
        @(negedge aclk);
    endtask

    // wait until all results are in and the block is quiet
    task automatic drain();
        s_valid <= 0;
        while (y_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_val();
        if ($urandom_range(0, 1)) return 16'($urandom);
        return 16'($signed($urandom_range(0, 1023)) - 512);
    endfunction

    // every entry that a start can read is written once before the first start
    task automatic fill_stores();
        for (int i = 0; i < AB_FILL; i++) send_item(gabb_pkg::ACT_LOAD_A, 7'(i), rand_val());
        for (int i = 0; i < AB_FILL; i++) send_item(gabb_pkg::ACT_LOAD_B, 7'(i), rand_val());
        for (int i = 0; i < C_FILL; i++) send_item(gabb_pkg::ACT_LOAD_C, 7'(i), rand_val());
    endtask

    task automatic test_reset_defaults();
        send_item(gabb_pkg::ACT_START, 7'h7f, 16'hffff);
        drain();
    endtask

    // extreme values, saturation both ways, overwrite of a loaded entry
    task automatic test_extremes();
        set_shape(2, 2, 2, 0, 0, 16'h8000, 16'h7fff, 4);
        send_item(gabb_pkg::ACT_LOAD_A, 0, 16'h7fff);
        send_item(gabb_pkg::ACT_LOAD_A, 0, 16'h8000);
        send_item(gabb_pkg::ACT_LOAD_A, 1, 16'h8000);
        send_item(gabb_pkg::ACT_LOAD_B, 0, 16'h8000);
        send_item(gabb_pkg::ACT_LOAD_B, 2, 16'h7fff);
        send_item(gabb_pkg::ACT_LOAD_C, 0, 16'h7fff);
        send_item(gabb_pkg::ACT_LOAD_C, 1, 16'h8000);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
        write_reg(gabb_pkg::REG_ALPHA, 16'h7fff);
        write_reg(gabb_pkg::REG_BETA, 16'h8000);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
    endtask

    // c beyond the store is ignored, unknown register index is ignored
    task automatic test_c_and_unknown_reg();
        send_item(gabb_pkg::ACT_LOAD_C, 7'd64, 16'h1234);
        send_item(gabb_pkg::ACT_LOAD_C, 7'd127, 16'h8001);
        write_reg(UNUSED_REG, 16'h0000);
        write_reg(8'd8, 16'hffff);
        set_shape(4, 3, 4, 0, 0, 256, 256, 64);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
        write_reg(gabb_pkg::REG_C_LEN, 5);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
    endtask

    task automatic test_transposes();
        for (int t = 0; t < 4; t++) begin
            set_shape(3, 4, 4, t[0], t[1], 16'h0180, 16'hff00, 7);
            send_item(gabb_pkg::ACT_START, 0, 0);
            drain();
        end
    endtask

    // oversized registers saturate, zero sizes give nothing or zero sums
    task automatic test_size_limits();
        set_shape(15, 2, 1, 1, 1, 16'h0040, 16'h0100, 127);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
        set_shape(1, 31, 1, 1, 1, 16'h0040, 16'h0100, 127);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
        set_shape(1, 2, 15, 1, 1, 16'h0040, 16'h0100, 127);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
        write_reg(gabb_pkg::REG_M_ROWS, 0);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
        write_reg(gabb_pkg::REG_M_ROWS, 2);
        write_reg(gabb_pkg::REG_N_COLS, 0);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
        write_reg(gabb_pkg::REG_N_COLS, 3);
        write_reg(gabb_pkg::REG_K_DEPTH, 0);
        send_item(gabb_pkg::ACT_START, 0, 0);
        drain();
    endtask

    // random phases: new shape, a burst of loads, then starts
    task automatic test_random();
        int kr, mr, nr;
        for (int ph = 0; ph < 9; ph++) begin
            no_idle = (ph % 3 == 2);
            // shapes keep every read inside the filled store region
            kr = $urandom_range(1, 16);
            mr = $urandom_range(1, (AB_FILL / kr > 8) ? 8 : AB_FILL / kr);
            nr = $urandom_range(1, (AB_FILL / kr > 8) ? 8 : AB_FILL / kr);
            if (ph == 0) set_shape(1, 16, 1, 1, 0, 16'h0100, 16'hffff, C_FILL);
            else if (ph == 1) set_shape(1, 1, 1, 0, 1, 16'h8000, 16'h8000, 1);
            else set_shape(mr, kr, nr,
                           $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1) ? 16'($urandom) : $urandom_range(0, 512),
                           16'($urandom), $urandom_range(0, C_FILL));
            repeat (3) begin
                gabb_pkg::action_t act;
                act = gabb_pkg::action_t'($urandom_range(0, 2));
                send_item(act, 7'($urandom), rand_val());
            end
            send_item(gabb_pkg::ACT_START, 7'($urandom), 16'($urandom));
            if (ph % 2 == 0) send_item(gabb_pkg::ACT_START, 7'($urandom), 16'($urandom));
            // every phase waits until all results are in; some phases drain twice
            if (ph % 4 == 1) drain();
            drain();
        end
        no_idle = 0;
    endtask

    // result stall per item
    always @(negedge aclk) begin
        m_ready <= (out_stall == 0);
        if (out_stall > 0) out_stall--;
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (y_expected.size() == 0) begin
                report_mismatch("unexpected result index", m_y_index, -1);
            end else begin
                y_elem_t e;
                e = y_expected.pop_front();
                if (m_y_index !== e.idx) report_mismatch("y_index", m_y_index, e.idx);
                if (m_y_value !== e.val) report_mismatch("y_value", m_y_value, e.val);
                if (m_last !== e.last) report_mismatch("last", m_last, e.last);
            end
            out_stall = no_idle ? 0 : $urandom_range(0, 4);
        end
    end

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        s_valid = 0;
        s_action = gabb_pkg::ACT_LOAD_A;
        s_position = 0;
        s_value = 0;
        m_ready = 0;
        rows_q = 1; depth_q = 1; cols_q = 1;
        ta_q = 0; tb_q = 0;
        alpha_q = 16'd256; beta_q = 16'd256;
        clen_q = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        fill_stores();
        test_reset_defaults();
        test_extremes();
        test_c_and_unknown_reg();
        test_transposes();
        test_size_limits();
        test_random();
        drain();
        if (mismatches == 0 && y_expected.size() == 0)
            $display("gemm_alpha_beta_bias_top test passed");
        else
            $display("gemm_alpha_beta_bias_top test failed");
        $finish;
    end
endmodule
